### design/lfu_cache_table_core_assert.svh
// Assertion macros for the checker file of the cache table.
`ifndef LFU_CACHE_TABLE_CORE_ASSERT_SVH
`define LFU_CACHE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define LFU_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfu cache table: assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define LFU_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfu cache table: assertion failed");

`endif

### design/lfu_pkg.sv
package lfu_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 16;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(ENTRIES);
    localparam logic [CAP_W-1:0] CAP_ONE   = CAP_W'(1);
    localparam logic [CNT_W-1:0] USE_MAX   = '1;
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [VAL_W-1:0] MINUS_ONE = '1;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } state_t;

    // What every cell does in the update cycle.
    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_TOUCH  = 2'd1,
        MODE_INSERT = 2'd2,
        MODE_EVICT  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
    } entry_t;

    // Broadcast to all cells: mode, count threshold and the entry to place.
    typedef struct packed {
        mode_t            mode;
        logic [CNT_W-1:0] thr;
        entry_t           fresh;
    } bcast_t;

    typedef struct packed {
        logic accept;
        logic apply;
    } ctrl_t;

endpackage

### design/lfu_cell.sv
module lfu_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head,
    input  logic [31:0]     probe_key,
    input  lfu_pkg::bcast_t bcast,
    input  logic            ge_p,
    input  logic            prev_valid,
    input  logic            prev_le,
    input  lfu_pkg::entry_t prev_entry,
    input  logic            next_valid,
    input  logic            next_le,
    input  lfu_pkg::entry_t next_entry,
    output logic            valid,
    output lfu_pkg::entry_t entry,
    output logic            match,
    output logic            le
);
    import lfu_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;

    assign valid = valid_reg;
    assign entry = entry_reg;
    assign match = valid_reg && (entry_reg.key == probe_key);
    assign le    = valid_reg && (entry_reg.count <= bcast.thr);

    // Cells stay sorted by eviction order, the victim in the head cell.
    // Each update moves a run of entries one place and drops one entry in.
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        case (bcast.mode)
            MODE_TOUCH:
            begin
                if (ge_p)
                begin
                    if (next_le)
                    begin
                        valid_next = next_valid;
                        entry_next = next_entry;
                    end
                    else if (le)
                    begin
                        valid_next = 1'b1;
                        entry_next = bcast.fresh;
                    end
                end
            end
            MODE_INSERT:
            begin
                if (!le)
                begin
                    if (head || prev_le)
                    begin
                        valid_next = 1'b1;
                        entry_next = bcast.fresh;
                    end
                    else if (prev_valid)
                    begin
                        valid_next = 1'b1;
                        entry_next = prev_entry;
                    end
                end
            end
            MODE_EVICT:
            begin
                if (next_le)
                begin
                    valid_next = next_valid;
                    entry_next = next_entry;
                end
                else if (head || le)
                begin
                    valid_next = 1'b1;
                    entry_next = bcast.fresh;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### design/lfu_ctrl.sv
module lfu_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           m_tready,
    output logic           s_tready,
    output logic           m_tvalid,
    output lfu_pkg::ctrl_t ctrl
);
    import lfu_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_tvalid)
                    state_next = S_APPLY;
            S_APPLY:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        ctrl.accept = 1'b0;
        ctrl.apply  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                ctrl.accept = s_tvalid;
            end
            S_APPLY:
                ctrl.apply = out_free;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.apply)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/lfu_cache_table_core.sv
// Channel  | Direction | Handshake          | Payload
// s        | in        | s_tvalid/s_tready  | tdata: key, value; tuser: op
// m        | out       | m_tvalid/m_tready  | tdata: read_value; tuser: hit, evicted
// cfg      | in        | cfg_valid/cfg_ready| cfg_data: capacity_in_use
//
// For every access, the key is matched against all cells in the accept cycle, and the
// cell row is updated and the result registered in the update state that follows.
// The cells shift by one place per update, so each access must see the previous one.
// A finished result waits in the output register; the next item is accepted meanwhile
// and only its update cycle stalls until that result is transferred.
// Reset clears all valid bits and sets the capacity to 16; it needs no clearing pass.
module lfu_cache_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] read_value
    output logic [1:0]  m_tuser,   // [0] hit, [1] evicted
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import lfu_pkg::*;

    ctrl_t            ctrl;
    bcast_t           bcast;
    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_eff;
    logic [CAP_W-1:0] cap_m1;
    logic [IDX_W-1:0] cap_idx;

    logic [ENTRIES-1:0] match_reg;
    logic [ENTRIES-1:0] match_now;
    logic [ENTRIES-1:0] ge_p;
    logic [ENTRIES-1:0] cell_valid;
    logic [ENTRIES-1:0] cell_le;
    entry_t             cell_entry [ENTRIES];

    op_t              op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;

    logic             hit;
    logic             full;
    entry_t           hit_entry;
    logic [CNT_W-1:0] cnt_new;

    logic [VAL_W-1:0] out_data_reg;
    logic             out_hit_reg;
    logic             out_evict_reg;

    lfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .ctrl     (ctrl)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_valid)
            cap_reg <= cfg_data;
    end

    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CAP_ONE;
        else if (cap_reg > CAP_MAX)
            cap_eff = CAP_MAX;
        else
            cap_eff = cap_reg;
    end

    assign cap_m1  = cap_eff - CAP_ONE;
    assign cap_idx = cap_m1[IDX_W-1:0];

    // Valid cells always fill the row from the head, so the fill reaches the
    // capacity exactly when the cell at capacity minus one is valid.
    assign full = cell_valid[cap_idx];

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            match_reg <= match_now;
            op_reg    <= op_t'(s_tuser[0]);
            key_reg   <= s_tdata[KEY_W-1:0];
            value_reg <= s_tdata[KEY_W+VAL_W-1:KEY_W];
        end
    end

    assign hit = |match_reg;

    always_comb
    begin
        hit_entry = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_reg[i])
                hit_entry = hit_entry | cell_entry[i];
        end
    end

    assign cnt_new = (hit_entry.count == USE_MAX) ? hit_entry.count
                                                  : hit_entry.count + CNT_ONE;

    always_comb
    begin
        ge_p[0] = match_reg[0];
        for (int i = 1; i < ENTRIES; i++)
            ge_p[i] = ge_p[i-1] | match_reg[i];
    end

    always_comb
    begin
        bcast.mode  = MODE_HOLD;
        bcast.thr   = CNT_ONE;
        bcast.fresh = '{key: key_reg, value: value_reg, count: CNT_ONE};
        if (ctrl.apply)
        begin
            if (hit)
            begin
                bcast.mode        = MODE_TOUCH;
                bcast.thr         = cnt_new;
                bcast.fresh.key   = hit_entry.key;
                bcast.fresh.count = cnt_new;
                bcast.fresh.value = (op_reg == OP_PUT) ? value_reg : hit_entry.value;
            end
            else if (op_reg == OP_PUT)
            begin
                bcast.mode = full ? MODE_EVICT : MODE_INSERT;
            end
        end
    end

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        logic   prev_valid;
        logic   prev_le;
        entry_t prev_entry;
        logic   next_valid;
        logic   next_le;
        entry_t next_entry;

        if (g == 0)
        begin : g_head
            assign prev_valid = 1'b0;
            assign prev_le    = 1'b0;
            assign prev_entry = '0;
        end
        else
        begin : g_body
            assign prev_valid = cell_valid[g-1];
            assign prev_le    = cell_le[g-1];
            assign prev_entry = cell_entry[g-1];
        end

        if (g == ENTRIES - 1)
        begin : g_tail
            assign next_valid = 1'b0;
            assign next_le    = 1'b0;
            assign next_entry = '0;
        end
        else
        begin : g_inner
            assign next_valid = cell_valid[g+1];
            assign next_le    = cell_le[g+1];
            assign next_entry = cell_entry[g+1];
        end

        lfu_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .head       (g == 0),
            .probe_key  (s_tdata[KEY_W-1:0]),
            .bcast      (bcast),
            .ge_p       (ge_p[g]),
            .prev_valid (prev_valid),
            .prev_le    (prev_le),
            .prev_entry (prev_entry),
            .next_valid (next_valid),
            .next_le    (next_le),
            .next_entry (next_entry),
            .valid      (cell_valid[g]),
            .entry      (cell_entry[g]),
            .match      (match_now[g]),
            .le         (cell_le[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.apply)
        begin
            out_hit_reg   <= hit;
            out_evict_reg <= !hit && (op_reg == OP_PUT) && full;
            out_data_reg  <= (hit && (op_reg == OP_GET)) ? hit_entry.value : MINUS_ONE;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = {out_evict_reg, out_hit_reg};

endmodule

### design/lfu_checker.sv
`include "lfu_cache_table_core_assert.svh"

module lfu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // An accepted item is worked on alone: the input closes for its update cycle.
    `LFU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // A result that waits keeps its contents until it is transferred.
    `LFU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Only a put of a missing key evicts, and a put reads back all ones.
    `LFU_ASSERT_NOW(a_evict_is_put_miss, m_tvalid && m_tuser[1], !m_tuser[0] && (m_tdata == '1))

    // When the output was empty, a result shows up once its accepted item has passed
    // through the update state into the output register.
    `LFU_ASSERT_NOW(a_result_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind lfu_cache_table_core lfu_checker u_lfu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/lfu_cache_table_checker.sv
module lfu_cache_table_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
    input  logic [0:0]  s_tuser,   // [0] op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] read_value
    input  logic [1:0]  m_tuser,   // [0] hit, [1] evicted
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    output int          mismatches,
    output int          outstanding,
    output int          accesses,
    output int          hits,
    output int          evictions
);
    timeunit 1ns;
    timeprecision 1ps;

    import lfu_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
    } access_result_t;

    // Shadow copy of the cache table.
    logic             slot_valid [ENTRIES];
    logic [KEY_W-1:0] slot_key   [ENTRIES];
    logic [VAL_W-1:0] slot_value [ENTRIES];
    logic [CNT_W-1:0] slot_uses  [ENTRIES];
    int               slot_age   [ENTRIES];
    logic [CAP_W-1:0] capacity;

    access_result_t   access_results_q [$];

    // Applies one access to the shadow table and returns what the block must answer.
    function automatic access_result_t predict_access(input op_t op,
                                                      input logic [KEY_W-1:0] key,
                                                      input logic [VAL_W-1:0] value);
        access_result_t res;
        int i;
        int found;
        int fill;
        int limit;
        int victim;
        int place;
        int rank;
        res.hit        = 1'b0;
        res.read_value = MINUS_ONE;
        res.evicted    = 1'b0;
        found = -1;
        for (i = 0; i < ENTRIES; i++)
            if (found < 0 && slot_valid[i] && slot_key[i] == key)
                found = i;
        if (found >= 0)
        begin
            // Entries touched more recently than this one each age by one.
            rank = slot_age[found];
            for (i = 0; i < ENTRIES; i++)
                if (slot_valid[i] && i != found && slot_age[i] < rank)
                    slot_age[i]++;
            slot_age[found] = 0;
            if (slot_uses[found] != USE_MAX)
                slot_uses[found]++;
            res.hit = 1'b1;
            if (op == OP_GET)
                res.read_value = slot_value[found];
            else
                slot_value[found] = value;
        end
        else if (op == OP_PUT)
        begin
            fill = 0;
            for (i = 0; i < ENTRIES; i++)
                if (slot_valid[i])
                    fill++;
            limit = int'(capacity);
            if (limit < 1)
                limit = 1;
            if (limit > ENTRIES)
                limit = ENTRIES;
            place = -1;
            if (fill >= limit)
            begin
                // Lowest use count loses; among equals the oldest touch loses.
                victim = -1;
                for (i = 0; i < ENTRIES; i++)
                    if (slot_valid[i] &&
                        (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                         (slot_uses[i] == slot_uses[victim] &&
                          slot_age[i] > slot_age[victim])))
                        victim = i;
                rank = slot_age[victim];
                slot_valid[victim] = 1'b0;
                for (i = 0; i < ENTRIES; i++)
                    if (slot_valid[i] && slot_age[i] > rank)
                        slot_age[i]--;
                place = victim;
                res.evicted = 1'b1;
            end
            for (i = 0; i < ENTRIES; i++)
                if (place < 0 && !slot_valid[i])
                    place = i;
            for (i = 0; i < ENTRIES; i++)
                if (slot_valid[i])
                    slot_age[i]++;
            slot_valid[place] = 1'b1;
            slot_key[place]   = key;
            slot_value[place] = value;
            slot_uses[place]  = CNT_ONE;
            slot_age[place]   = 0;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        access_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                slot_valid[i] = 1'b0;
            capacity = CAP_RESET;
            access_results_q.delete();
            mismatches  = 0;
            outstanding = 0;
            accesses    = 0;
            hits        = 0;
            evictions   = 0;
        end
        else
        begin
            // A result leaving now always belongs to an access accepted earlier,
            // so it is checked before this edge's access is predicted.
            if (m_tvalid && m_tready)
            begin
                if (access_results_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no access pending: expected none, actual "
                             , $time, "hit %0d read_value %h evicted %0d",
                             m_tuser[0], m_tdata, m_tuser[1]);
                end
                else
                begin
                    want = access_results_q.pop_front();
                    if (m_tuser[0] !== want.hit)
                    begin
                        mismatches++;
                        $display("%0t: hit mismatch: expected %0d, actual %0d",
                                 $time, want.hit, m_tuser[0]);
                    end
                    if (m_tdata !== want.read_value)
                    begin
                        mismatches++;
                        $display("%0t: read_value mismatch: expected %h, actual %h",
                                 $time, want.read_value, m_tdata);
                    end
                    if (m_tuser[1] !== want.evicted)
                    begin
                        mismatches++;
                        $display("%0t: evicted mismatch: expected %0d, actual %0d",
                                 $time, want.evicted, m_tuser[1]);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (s_tvalid && s_tready)
            begin
                want = predict_access(op_t'(s_tuser[0]), s_tdata[31:0], s_tdata[63:32]);
                access_results_q.push_back(want);
                accesses++;
                if (want.hit)
                    hits++;
                if (want.evicted)
                    evictions++;
            end
            outstanding = access_results_q.size();
        end
    end

endmodule

### tb/tb_lfu_cache_table_core.sv
module tb_lfu_cache_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lfu_pkg::*;

    localparam int SOAK_LOOKUPS = 24;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;   // [31:0] key, [63:32] value
    logic [0:0]  s_tuser   = '0;   // [0] op
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [31:0] m_tdata;          // [31:0] read_value
    logic [1:0]  m_tuser;          // [0] hit, [1] evicted
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data  = '0;

    int mismatches;
    int outstanding;
    int accesses;
    int hits;
    int evictions;

    logic        stall_on = 1'b1;
    int          stall_mode = 0;
    int          stall_left = 0;
    int          stall_tick = 0;
    int          settings_used = 1;
    logic [31:0] key_pool [24];

    lfu_cache_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lfu_cache_table_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .accesses    (accesses),
        .hits        (hits),
        .evictions   (evictions)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // The receiver switches between randomly chosen stall patterns, or is always ready when stalls are off.
    always @(negedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (!stall_on)
            m_tready <= 1'b1;
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(8, 64);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (stall_tick % 4 == 0);
                default: m_tready <= stall_tick[2];
            endcase
        end
    end

    task automatic send_item(input op_t op, input logic [31:0] key, input logic [31:0] value);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {value, key};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        pause_sender(1);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly keys from a small window of the pool so that hits, updates and
    // evictions dominate; the rest are fresh random keys.
    task automatic run_phase(input int items, input int window);
        int          burst;
        int          k;
        logic [31:0] key;
        burst = 0;
        for (k = 0; k < items; k++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 2) != 0)
                    pause_sender($urandom_range(1, 8));
            end
            burst--;
            if (k == items / 2)
                wait_drained();
            if ($urandom_range(0, 4) == 0)
                key = $urandom();
            else
                key = key_pool[$urandom_range(0, window)];
            send_item(op_t'($urandom_range(0, 1)), key, $urandom());
        end
    endtask

    initial
    begin
        int k;
        for (k = 0; k < 24; k++)
            key_pool[k] = $urandom();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed accesses at the reset capacity of 16.
        send_item(OP_GET, 32'h0000_0000, 32'h1234_5678);
        send_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
        // A stored all-ones value reads back like a miss but with hit set.
        send_item(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
        for (k = 0; k < 13; k++)
            send_item(OP_PUT, 32'h0000_0100 + k, $urandom());
        // Table is full: a new key evicts the oldest of the least used entries.
        send_item(OP_PUT, 32'h5555_AAAA, 32'hAAAA_5555);
        send_item(OP_GET, 32'h0000_0100, 32'h0000_0000);

        // Capacity dropped below the current fill.
        set_capacity(5'd3);
        run_phase(110, 23);
        set_capacity(5'd0);
        run_phase(100, 5);
        set_capacity(5'd31);
        run_phase(110, 23);
        set_capacity(5'd1);
        run_phase(100, 3);

        // Hit one entry many times back to back without stalls, then check
        // that it survives evictions around it.
        set_capacity(5'd4);
        stall_on = 1'b0;
        send_item(OP_PUT, key_pool[0], $urandom());
        for (k = 0; k < SOAK_LOOKUPS; k++)
            send_item(OP_GET, key_pool[0], $urandom());
        wait_drained();
        stall_on = 1'b1;
        run_phase(80, 8);

        set_capacity(5'd16);
        run_phase(110, 23);
        set_capacity(5'd2);
        run_phase(100, 6);
        set_capacity(5'd9);
        run_phase(100, 14);
        for (k = 0; k < 3; k++)
        begin
            set_capacity(5'($urandom_range(0, 31)));
            run_phase(70, $urandom_range(3, 23));
        end

        wait_drained();
        repeat (16) @(negedge clk);
        $display("Run covered %0d accesses (%0d hits, %0d evictions) over %0d capacity settings,",
                 accesses, hits, evictions, settings_used);
        $display("including a %0d-lookup run on one key with the output never stalled.",
                 SOAK_LOOKUPS);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
